// File: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define C2S2_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define C2S2_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/c2s2_pkg.sv
// Types and constants shared by the stride-2 convolution engine.
package c2s2_pkg;

   // Item op codes
   localparam logic [1:0] OP_WEIGHT  = 2'd0;
   localparam logic [1:0] OP_BIAS    = 2'd1;
   localparam logic [1:0] OP_SAMPLE  = 2'd2;
   localparam logic [1:0] OP_COMPUTE = 2'd3;

   // Configuration register indexes
   localparam logic [2:0] REG_IN_CHANNELS = 3'd0;
   localparam logic [2:0] REG_IN_HEIGHT   = 3'd1;
   localparam logic [2:0] REG_IN_WIDTH    = 3'd2;
   localparam logic [2:0] REG_KERNEL_SIZE = 3'd3;
   localparam logic [2:0] REG_BIAS_ENABLE = 3'd4;
   localparam logic [2:0] REG_ACTIVATION  = 3'd5;

   // Activation codes
   localparam logic [1:0] ACT_RELU   = 2'd1;
   localparam logic [1:0] ACT_HSWISH = 2'd2;

   // Accumulator width: 4 channels x 49 taps of Q8.8 x Q8.8 plus bias
   localparam int ACC_W = 41;
   localparam int LANES = 4;

   typedef struct packed {
      logic [1:0]         op;
      logic [4:0]         out_channel;
      logic [1:0]         in_channel;
      logic [5:0]         row;
      logic [5:0]         col;
      logic signed [15:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_lane0;
      logic signed [31:0] result_lane1;
      logic signed [31:0] result_lane2;
      logic signed [31:0] result_lane3;
      logic [4:0]         result_channel_base;
      logic [4:0]         result_row;
      logic [4:0]         result_col;
      logic               range_error;
   } rsp_type;

   typedef struct packed {
      logic [2:0] in_channels;
      logic [6:0] in_height;
      logic [6:0] in_width;
      logic [2:0] kernel_size;
      logic       bias_enable;
      logic [1:0] activation;
   } cfg_type;

   typedef enum logic [2:0] {
      KIND_WEIGHT,
      KIND_BIAS,
      KIND_SAMPLE,
      KIND_COMPUTE,
      KIND_DROP
   } kind_type;

   typedef struct packed {
      kind_type kind;
      req_type  item;
   } qent_type;

   typedef struct packed {
      logic [1:0] count;
      logic       full;
   } qstat_type;

endpackage

// File: rtl/c2s2_front.sv
// Front end: accepts items, classifies them and queues them for the back end.
module c2s2_front #(
   parameter int MAX_IN_CHANNELS  = 4,
   parameter int MAX_OUT_CHANNELS = 32,
   parameter int MAX_IN_HEIGHT    = 64,
   parameter int MAX_IN_WIDTH     = 64,
   parameter int MAX_KERNEL       = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  c2s2_pkg::req_type    req_data,
   output logic                 head_valid,
   output c2s2_pkg::qent_type   head,
   input  logic                 head_pop,
   output c2s2_pkg::qstat_type  stat
);

   c2s2_pkg::qent_type slot_ff [2];
   c2s2_pkg::qent_type ent;
   logic               wr_ptr_ff, rd_ptr_ff;
   logic [1:0]         count_ff;
   logic               push, pop;

   // Classify: loads outside the stores are marked for dropping here
   always_comb begin
      ent.item = req_data;
      case (req_data.op)
         c2s2_pkg::OP_WEIGHT:
            ent.kind = (int'(req_data.out_channel) < MAX_OUT_CHANNELS &&
                        int'(req_data.in_channel) < MAX_IN_CHANNELS &&
                        int'(req_data.row) < MAX_KERNEL &&
                        int'(req_data.col) < MAX_KERNEL) ?
                       c2s2_pkg::KIND_WEIGHT : c2s2_pkg::KIND_DROP;
         c2s2_pkg::OP_BIAS:
            ent.kind = (int'(req_data.out_channel) < MAX_OUT_CHANNELS) ?
                       c2s2_pkg::KIND_BIAS : c2s2_pkg::KIND_DROP;
         c2s2_pkg::OP_SAMPLE:
            ent.kind = (int'(req_data.in_channel) < MAX_IN_CHANNELS &&
                        int'(req_data.row) < MAX_IN_HEIGHT &&
                        int'(req_data.col) < MAX_IN_WIDTH) ?
                       c2s2_pkg::KIND_SAMPLE : c2s2_pkg::KIND_DROP;
         default:
            ent.kind = c2s2_pkg::KIND_COMPUTE;
      endcase
   end

   assign req_stall  = (count_ff == 2'd2);
   assign push       = req_valid && !req_stall;
   assign head_valid = (count_ff != 2'd0);
   assign pop        = head_pop && head_valid;
   assign head       = slot_ff[rd_ptr_ff];
   assign stat.count = count_ff;
   assign stat.full  = req_stall;

   // Queue pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         if (push && !pop)      count_ff <= count_ff + 2'd1;
         else if (pop && !push) count_ff <= count_ff - 2'd1;
      end
   end

   // Queue entries
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= ent;
   end

endmodule

// File: rtl/c2s2_back.sv
// Back end: stores, four-lane multiply-accumulate sequencer, activation, result register.
module c2s2_back #(
   parameter int MAX_IN_CHANNELS  = 4,
   parameter int MAX_OUT_CHANNELS = 32,
   parameter int MAX_IN_HEIGHT    = 64,
   parameter int MAX_IN_WIDTH     = 64,
   parameter int MAX_KERNEL       = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  c2s2_pkg::cfg_type   cfg,
   input  logic                head_valid,
   input  c2s2_pkg::qent_type  head,
   output logic                head_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output c2s2_pkg::rsp_type   rsp_data
);

   localparam int ACC_W = c2s2_pkg::ACC_W;
   localparam int LANES = c2s2_pkg::LANES;
   localparam int GRPS  = (MAX_OUT_CHANNELS + LANES - 1) / LANES;
   localparam int GA_W  = (GRPS > 1) ? $clog2(GRPS) : 1;
   localparam int WB_D  = GRPS * MAX_IN_CHANNELS * MAX_KERNEL * MAX_KERNEL;
   localparam int WA_W  = $clog2(WB_D);
   localparam int S_D   = MAX_IN_CHANNELS * MAX_IN_HEIGHT * MAX_IN_WIDTH;
   localparam int SA_W  = $clog2(S_D);
   localparam int C_W   = $clog2(MAX_IN_CHANNELS + 1);
   localparam logic signed [ACC_W-1:0] HS_THREE = ACC_W'(3 * 65536);
   localparam logic [18:0] T_OFS = 19'd196608;
   localparam logic [19:0] RECIP3 = 20'd699051;

   typedef enum logic [2:0] {
      ST_IDLE, ST_BIAS, ST_MAC, ST_DRAIN, ST_ACT1, ST_ACT2, ST_SAT
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff, mv_ff;
   c2s2_pkg::rsp_type rsp_data_ff, res;

   // Latched compute item
   logic [GA_W-1:0] grp_ff;
   logic [4:0]      base_ff;
   logic [5:0]      row_ff, col_ff;
   logic [C_W-1:0]  nc_ff, c_ff;
   logic [2:0]      k_ff, kr_ff, kc_ff;
   logic            err_ff;

   // Datapath registers
   logic signed [ACC_W-1:0] acc_ff  [LANES];
   logic signed [38:0]      prod_ff [LANES];
   logic [18:0]             q_ff    [LANES];
   logic                    neg_ff  [LANES], hi_ff [LANES], lo_ff [LANES];

   // Memory read data
   logic signed [15:0] s_q;
   logic signed [15:0] w_q [LANES];
   logic signed [15:0] b_q [LANES];

   logic            is_idle_pop, is_compute, cmp_err, last_tap, empty_sum;
   logic [C_W-1:0]  nc_eff;
   logic [2:0]      k_eff;
   logic [4:0]      head_base;
   logic [GA_W-1:0] head_grp;
   logic [SA_W-1:0] s_waddr, s_raddr;
   logic [WA_W-1:0] w_waddr, w_raddr;

   // Item decode from the queue head
   assign is_idle_pop = (state_ff == ST_IDLE) && head_valid;
   assign head_pop    = is_idle_pop;
   assign is_compute  = (head.kind == c2s2_pkg::KIND_COMPUTE);
   assign head_base   = {head.item.out_channel[4:2], 2'b00};
   assign head_grp    = GA_W'(head.item.out_channel[4:2]);
   assign nc_eff = C_W'((int'(cfg.in_channels) > MAX_IN_CHANNELS) ?
                        MAX_IN_CHANNELS : int'(cfg.in_channels));
   assign k_eff  = 3'((int'(cfg.kernel_size) > MAX_KERNEL) ?
                      MAX_KERNEL : int'(cfg.kernel_size));

   // Range check of the group and of the kernel window
   always_comb begin
      int h_eff, w_eff;
      h_eff = (int'(cfg.in_height) > MAX_IN_HEIGHT) ? MAX_IN_HEIGHT : int'(cfg.in_height);
      w_eff = (int'(cfg.in_width) > MAX_IN_WIDTH) ? MAX_IN_WIDTH : int'(cfg.in_width);
      cmp_err = (int'(head_base) + LANES > MAX_OUT_CHANNELS) ||
                ((k_eff != 3'd0) &&
                 ((2 * int'(head.item.row) + int'(k_eff) > h_eff) ||
                  (2 * int'(head.item.col) + int'(k_eff) > w_eff)));
   end

   // Store addresses
   assign s_waddr = SA_W'((int'(head.item.in_channel) * MAX_IN_HEIGHT + int'(head.item.row))
                          * MAX_IN_WIDTH + int'(head.item.col));
   assign w_waddr = WA_W'(((int'(head.item.out_channel[4:2]) * MAX_IN_CHANNELS
                           + int'(head.item.in_channel)) * MAX_KERNEL
                           + int'(head.item.row)) * MAX_KERNEL + int'(head.item.col));
   assign s_raddr = SA_W'((int'(c_ff) * MAX_IN_HEIGHT + 2 * int'(row_ff) + int'(kr_ff))
                          * MAX_IN_WIDTH + 2 * int'(col_ff) + int'(kc_ff));
   assign w_raddr = WA_W'(((int'(grp_ff) * MAX_IN_CHANNELS + int'(c_ff)) * MAX_KERNEL
                           + int'(kr_ff)) * MAX_KERNEL + int'(kc_ff));

   // Sample store
   logic signed [15:0] smem [S_D];
   always_ff @(posedge clock) begin
      if (is_idle_pop && head.kind == c2s2_pkg::KIND_SAMPLE) smem[s_waddr] <= head.item.value;
      s_q <= smem[s_raddr];
   end

   // Weight and bias banks, one per lane
   for (genvar l = 0; l < LANES; l++) begin : g_bank
      logic signed [15:0] wmem [WB_D];
      logic signed [15:0] bmem [GRPS];
      logic               lane_hit;
      assign lane_hit = (int'(head.item.out_channel[1:0]) == l);
      always_ff @(posedge clock) begin
         if (is_idle_pop && head.kind == c2s2_pkg::KIND_WEIGHT && lane_hit)
            wmem[w_waddr] <= head.item.value;
         if (is_idle_pop && head.kind == c2s2_pkg::KIND_BIAS && lane_hit)
            bmem[head_grp] <= head.item.value;
         w_q[l] <= wmem[w_raddr];
         b_q[l] <= bmem[head_grp];
      end
   end

   assign last_tap  = (kc_ff == k_ff - 3'd1) && (kr_ff == k_ff - 3'd1) &&
                      (c_ff == nc_ff - C_W'(1));
   assign empty_sum = (nc_ff == '0) || (k_ff == 3'd0);

   // Control FSM and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mv_ff        <= 1'b0;
      end else begin
         mv_ff <= (state_ff == ST_MAC);
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE:
               if (is_idle_pop && is_compute) state_ff <= cmp_err ? ST_SAT : ST_BIAS;
            ST_BIAS:  state_ff <= empty_sum ? ST_ACT1 : ST_MAC;
            ST_MAC:   if (last_tap) state_ff <= ST_DRAIN;
            ST_DRAIN: state_ff <= ST_ACT1;
            ST_ACT1:  state_ff <= ST_ACT2;
            ST_ACT2:  state_ff <= ST_SAT;
            ST_SAT:
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= res;
                  state_ff     <= ST_IDLE;
               end
            default:  state_ff <= ST_IDLE;
         endcase
      end
   end

   // Sequencer counters and lane datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE:
            if (is_idle_pop && is_compute) begin
               grp_ff  <= head_grp;
               base_ff <= head_base;
               row_ff  <= head.item.row;
               col_ff  <= head.item.col;
               nc_ff   <= nc_eff;
               k_ff    <= k_eff;
               err_ff  <= cmp_err;
            end
         ST_BIAS: begin
            c_ff  <= '0;
            kr_ff <= 3'd0;
            kc_ff <= 3'd0;
            for (int l = 0; l < LANES; l++)
               acc_ff[l] <= cfg.bias_enable ?
                            {{(ACC_W-24){b_q[l][15]}}, b_q[l], 8'h00} : '0;
         end
         ST_MAC:
            if (kc_ff != k_ff - 3'd1) kc_ff <= kc_ff + 3'd1;
            else begin
               kc_ff <= 3'd0;
               if (kr_ff != k_ff - 3'd1) kr_ff <= kr_ff + 3'd1;
               else begin
                  kr_ff <= 3'd0;
                  c_ff  <= c_ff + C_W'(1);
               end
            end
         ST_ACT1:
            // hard swish middle range: x * clamp(x + 3, 0, 6)
            for (int l = 0; l < LANES; l++) begin
               prod_ff[l] <= $signed(acc_ff[l][18:0]) *
                             $signed({1'b0, acc_ff[l][18:0] + T_OFS});
               hi_ff[l]   <= (acc_ff[l] >= HS_THREE);
               lo_ff[l]   <= (acc_ff[l] <= -HS_THREE);
            end
         ST_ACT2:
            // divide magnitude by 6 << 16: shift by 17, then reciprocal of 3
            for (int l = 0; l < LANES; l++) begin
               logic [38:0] mag;
               logic [39:0] qp;
               mag = prod_ff[l][38] ? 39'(-prod_ff[l]) : 39'(prod_ff[l]);
               qp  = mag[36:17] * RECIP3;
               q_ff[l]   <= qp[39:21];
               neg_ff[l] <= prod_ff[l][38];
            end
         default: ;
      endcase
      if (mv_ff)
         for (int l = 0; l < LANES; l++) begin
            logic signed [31:0] p;
            p = s_q * w_q[l];
            acc_ff[l] <= acc_ff[l] + ACC_W'(p);
         end
   end

   // Activation select and saturation
   always_comb begin
      logic signed [ACC_W-1:0] y, hs;
      logic signed [31:0]      lane [LANES];
      for (int l = 0; l < LANES; l++) begin
         hs = neg_ff[l] ? -ACC_W'({1'b0, q_ff[l]}) : ACC_W'({1'b0, q_ff[l]});
         case (cfg.activation)
            c2s2_pkg::ACT_RELU:   y = acc_ff[l][ACC_W-1] ? '0 : acc_ff[l];
            c2s2_pkg::ACT_HSWISH: y = hi_ff[l] ? acc_ff[l] : (lo_ff[l] ? '0 : hs);
            default:              y = acc_ff[l];
         endcase
         if (err_ff)                                 lane[l] = '0;
         else if (y > ACC_W'(64'sh7FFF_FFFF))        lane[l] = 32'sh7FFF_FFFF;
         else if (y < ACC_W'(-64'sh8000_0000))       lane[l] = 32'sh8000_0000;
         else                                        lane[l] = y[31:0];
      end
      res.result_lane0        = lane[0];
      res.result_lane1        = lane[1];
      res.result_lane2        = lane[2];
      res.result_lane3        = lane[3];
      res.result_channel_base = base_ff;
      res.result_row          = row_ff[4:0];
      res.result_col          = col_ff[4:0];
      res.range_error         = err_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/conv2d_stride2_oc4_engine.sv
// Top level of the stride-2 four-output-channel convolution engine.

// Load items (weight, bias, sample) pass through the queue and are written to
// their store when the back end pops them. A compute item runs a single
// multiply-accumulate pass over in_channels * kernel_size^2 taps, in which the
// four lanes share one sample read per tap from the sample store. Out-of-frame
// or out-of-store groups skip the pass and return range_error with zero lanes.
// A two-entry queue lets new items be accepted while a pixel is computed, and a
// result register holds a finished result until it is taken. Stores have
// undefined contents until written.
`include "assert_macros.svh"

module conv2d_stride2_oc4_engine #(
   parameter int MAX_IN_CHANNELS  = 4,
   parameter int MAX_OUT_CHANNELS = 32,
   parameter int MAX_IN_HEIGHT    = 64,
   parameter int MAX_IN_WIDTH     = 64,
   parameter int MAX_KERNEL       = 7
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  c2s2_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output c2s2_pkg::rsp_type  rsp_data,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [6:0]         csr_wdata
);

   c2s2_pkg::cfg_type   cfg_ff;
   c2s2_pkg::qent_type  head;
   c2s2_pkg::qstat_type qstat;
   logic                head_valid, head_pop;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.in_channels <= 3'd3;
         cfg_ff.in_height   <= 7'd64;
         cfg_ff.in_width    <= 7'd64;
         cfg_ff.kernel_size <= 3'd3;
         cfg_ff.bias_enable <= 1'b1;
         cfg_ff.activation  <= 2'd0;
      end else if (csr_write) begin
         case (csr_index)
            c2s2_pkg::REG_IN_CHANNELS: cfg_ff.in_channels <= csr_wdata[2:0];
            c2s2_pkg::REG_IN_HEIGHT:   cfg_ff.in_height   <= csr_wdata;
            c2s2_pkg::REG_IN_WIDTH:    cfg_ff.in_width    <= csr_wdata;
            c2s2_pkg::REG_KERNEL_SIZE: cfg_ff.kernel_size <= csr_wdata[2:0];
            c2s2_pkg::REG_BIAS_ENABLE: cfg_ff.bias_enable <= csr_wdata[0];
            c2s2_pkg::REG_ACTIVATION:  cfg_ff.activation  <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   c2s2_front #(
      .MAX_IN_CHANNELS (MAX_IN_CHANNELS),
      .MAX_OUT_CHANNELS(MAX_OUT_CHANNELS),
      .MAX_IN_HEIGHT   (MAX_IN_HEIGHT),
      .MAX_IN_WIDTH    (MAX_IN_WIDTH),
      .MAX_KERNEL      (MAX_KERNEL)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .head_valid(head_valid),
      .head      (head),
      .head_pop  (head_pop),
      .stat      (qstat)
   );

   c2s2_back #(
      .MAX_IN_CHANNELS (MAX_IN_CHANNELS),
      .MAX_OUT_CHANNELS(MAX_OUT_CHANNELS),
      .MAX_IN_HEIGHT   (MAX_IN_HEIGHT),
      .MAX_IN_WIDTH    (MAX_IN_WIDTH),
      .MAX_KERNEL      (MAX_KERNEL)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head_valid(head_valid),
      .head      (head),
      .head_pop  (head_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Checks
   `C2S2_ASSERT(a_err_zero, clock, reset, rsp_valid && rsp_data.range_error |-> rsp_data.result_lane0 == 0 && rsp_data.result_lane1 == 0 && rsp_data.result_lane2 == 0 && rsp_data.result_lane3 == 0, "range error with nonzero lanes")
   `C2S2_ASSERT(a_q_bound, clock, reset, qstat.count != 2'd3, "queue count overflow")
   `C2S2_ASSERT(a_q_land, clock, reset, req_valid && !req_stall |=> qstat.count != 2'd0, "accepted transfer lost from queue")

endmodule

// File: tb/sv/tb_conv2d_stride2_oc4_engine.sv
// Self-checking testbench for the stride-2 four-channel convolution engine.
module tb_conv2d_stride2_oc4_engine;
   timeunit 1ns;
   timeprecision 1ps;
   import c2s2_pkg::*;

   localparam int N_CH = 4;
   localparam int N_OC = 32;
   localparam int N_H = 64;
   localparam int N_W = 64;
   localparam int N_K = 7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_write = 1'b0;
   logic [2:0] csr_index = '0;
   logic [6:0] csr_wdata = '0;

   conv2d_stride2_oc4_engine u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Shadow of the block's stores and registers
   logic signed [15:0] sample_mem [N_CH][N_H][N_W];
   logic signed [15:0] weight_mem [N_OC][N_CH][N_K][N_K];
   logic signed [15:0] bias_mem [N_OC];
   bit sample_ok [N_CH][N_H][N_W];
   bit weight_ok [N_OC][N_CH][N_K][N_K];
   bit bias_ok [N_OC];
   logic [2:0] cfg_ch = 3'd3;
   logic [6:0] cfg_h = 7'd64;
   logic [6:0] cfg_w = 7'd64;
   logic [2:0] cfg_k = 3'd3;
   logic cfg_bias = 1'b1;
   logic [1:0] cfg_act = 2'd0;

   req_type pending_reqs [$];
   rsp_type pixel_results [$];
   int mismatches = 0;
   int drv_wait = 0;
   int mon_wait = 0;

   function automatic logic signed [31:0] clip32(longint x);
      if (x > 64'sd2147483647) return 32'sh7fffffff;
      if (x < -64'sd2147483648) return 32'sh80000000;
      return x[31:0];
   endfunction

   function automatic longint activate(longint x);
      longint t;
      if (cfg_act == ACT_RELU) return (x < 0) ? 0 : x;
      if (cfg_act == ACT_HSWISH) begin
         t = x + 3 * 65536;
         if (t < 0) t = 0;
         if (t > 6 * 65536) t = 6 * 65536;
         return (x * t) / (6 * 65536);
      end
      return x;
   endfunction

   // Update the shadow stores; return 1 with the expected result on compute
   function automatic bit conv_predict(req_type r, output rsp_type res);
      int base, nc, h, w, k, r0, c0;
      bit err;
      longint acc;
      logic signed [31:0] lanes [4];
      res = '0;
      case (r.op)
         OP_WEIGHT: begin
            if (r.row < N_K && r.col < N_K)
               weight_mem[r.out_channel][r.in_channel][r.row][r.col] = r.value;
            return 0;
         end
         OP_BIAS: begin
            bias_mem[r.out_channel] = r.value;
            return 0;
         end
         OP_SAMPLE: begin
            sample_mem[r.in_channel][r.row][r.col] = r.value;
            return 0;
         end
         default: ;
      endcase
      base = r.out_channel & ~5'd3;
      nc = (cfg_ch > N_CH) ? N_CH : cfg_ch;
      h = (cfg_h > N_H) ? N_H : cfg_h;
      w = (cfg_w > N_W) ? N_W : cfg_w;
      k = (cfg_k > N_K) ? N_K : cfg_k;
      r0 = 2 * r.row;
      c0 = 2 * r.col;
      err = (base + LANES > N_OC) || (k > 0 && (r0 + k > h || c0 + k > w));
      for (int ln = 0; ln < 4; ln++) begin
         acc = 0;
         if (!err) begin
            if (cfg_bias) acc = longint'(bias_mem[base + ln]) * 256;
            for (int c = 0; c < nc; c++)
               for (int kr = 0; kr < k; kr++)
                  for (int kc = 0; kc < k; kc++)
                     acc += longint'(sample_mem[c][r0 + kr][c0 + kc]) *
                            longint'(weight_mem[base + ln][c][kr][kc]);
            acc = activate(acc);
         end
         lanes[ln] = clip32(acc);
      end
      res.result_lane0 = lanes[0];
      res.result_lane1 = lanes[1];
      res.result_lane2 = lanes[2];
      res.result_lane3 = lanes[3];
      res.result_channel_base = base[4:0];
      res.result_row = r.row[4:0];
      res.result_col = r.col[4:0];
      res.range_error = err;
      return 1;
   endfunction

   // Driver: one transfer per queued item, random gap between transfers
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall_q) begin
            req_valid <= 1'b0;
            drv_wait <= $urandom_range(0, 13);
         end else if (!req_valid) begin
            if (drv_wait > 0) drv_wait <= drv_wait - 1;
            else if (pending_reqs.size() > 0) begin
               req_data <= pending_reqs.pop_front();
               req_valid <= 1'b1;
            end
         end
      end
   end

   // Stall seen at the last rising edge, with the valid that was sampled there
   logic req_stall_q = 1'b1;
   logic req_taken = 1'b0;
   always @(posedge clock) begin
      req_stall_q <= req_stall;
      req_taken <= req_valid && !req_stall && !reset;
   end

   // Predict at the rising edge where the input transfer happens
   always @(posedge clock) begin
      rsp_type exp_res;
      if (!reset && req_valid && !req_stall)
         if (conv_predict(req_data, exp_res)) pixel_results.push_back(exp_res);
   end

   // Monitor: compare each output transfer with the oldest expected pixel
   always @(posedge clock) begin
      rsp_type exp_res;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pixel_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", rsp_data);
         end else begin
            exp_res = pixel_results.pop_front();
            if (rsp_data !== exp_res) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %h actual %h", exp_res, rsp_data);
            end
         end
      end
   end

   // Random stall on the result side, drawn while a result is valid
   always @(negedge clock) begin
      if (mon_wait > 0) begin
         mon_wait <= mon_wait - 1;
         rsp_stall <= 1'b1;
      end else if (rsp_stall) begin
         rsp_stall <= 1'b0;
      end else if (rsp_valid && ($urandom_range(0, 3) == 0)) begin
         mon_wait <= $urandom_range(0, 13);
         rsp_stall <= 1'b1;
      end
   end

   task automatic csr_put(logic [2:0] idx, logic [6:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         REG_IN_CHANNELS: cfg_ch = val[2:0];
         REG_IN_HEIGHT:   cfg_h = val;
         REG_IN_WIDTH:    cfg_w = val;
         REG_KERNEL_SIZE: cfg_k = val[2:0];
         REG_BIAS_ENABLE: cfg_bias = val[0];
         default:         cfg_act = val[1:0];
      endcase
   endtask

   // Wait until every queued item is sent and every pixel has come back
   task automatic drain();
      wait (pending_reqs.size() == 0 && !req_valid);
      wait (pixel_results.size() == 0);
      repeat (220) @(posedge clock);
   endtask

   function automatic req_type mk(logic [1:0] op, int oc, int ic, int r, int c,
                                  int v);
      req_type q;
      q.op = op;
      q.out_channel = oc;
      q.in_channel = ic;
      q.row = r;
      q.col = c;
      q.value = v;
      return q;
   endfunction

   // Fill every store entry a compute under the current setting may read
   task automatic load_all(int big);
      int nc, h, w, k;
      nc = (cfg_ch > N_CH) ? N_CH : cfg_ch;
      h = (cfg_h > N_H) ? N_H : cfg_h;
      w = (cfg_w > N_W) ? N_W : cfg_w;
      k = (cfg_k > N_K) ? N_K : cfg_k;
      for (int o = 0; o < N_OC; o++) begin
         pending_reqs.push_back(mk(OP_BIAS, o, $urandom, $urandom, $urandom,
                                   big ? 16'sh7fff : $urandom));
         bias_ok[o] = 1;
         for (int c = 0; c < nc; c++)
            for (int a = 0; a < k; a++)
               for (int b = 0; b < k; b++) begin
                  pending_reqs.push_back(mk(OP_WEIGHT, o, c, a, b,
                                            big ? 16'sh8000 : $urandom));
                  weight_ok[o][c][a][b] = 1;
               end
      end
      for (int c = 0; c < nc; c++)
         for (int a = 0; a < h; a++)
            for (int b = 0; b < w; b++) begin
               pending_reqs.push_back(mk(OP_SAMPLE, 0, c, a, b,
                                         big ? 16'sh8000 : $urandom));
               sample_ok[c][a][b] = 1;
            end
   endtask

   // Compute item at a random pixel; most land inside the frame
   function automatic req_type rand_compute();
      int h, w, k, rmax, cmax;
      h = (cfg_h > N_H) ? N_H : cfg_h;
      w = (cfg_w > N_W) ? N_W : cfg_w;
      k = (cfg_k > N_K) ? N_K : cfg_k;
      rmax = (h - k) / 2;
      cmax = (w - k) / 2;
      if ($urandom_range(0, 5) == 0 || rmax < 0 || cmax < 0)
         return mk(OP_COMPUTE, $urandom, $urandom, $urandom, $urandom, $urandom);
      return mk(OP_COMPUTE, $urandom_range(0, 27), $urandom, $urandom_range(0, rmax),
                $urandom_range(0, cmax), $urandom);
   endfunction

   int settings [6][6] = '{
      '{1, 8, 8, 2, 0, 1},
      '{4, 16, 16, 7, 1, 2},
      '{2, 12, 10, 3, 1, 0},
      '{3, 14, 14, 5, 0, 3},
      '{4, 64, 64, 7, 1, 2},
      '{1, 1, 1, 2, 1, 1}
   };

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // Directed: small frame, extremes, the top channel group and out-of-frame pixels
      csr_put(REG_IN_CHANNELS, 1);
      csr_put(REG_IN_HEIGHT, 4);
      csr_put(REG_IN_WIDTH, 4);
      csr_put(REG_KERNEL_SIZE, 2);
      csr_put(REG_BIAS_ENABLE, 1);
      csr_put(REG_ACTIVATION, 0);
      load_all(1);
      pending_reqs.push_back(mk(OP_COMPUTE, 0, 3, 0, 0, 0));
      pending_reqs.push_back(mk(OP_COMPUTE, 27, 0, 1, 1, 16'sh7fff));
      pending_reqs.push_back(mk(OP_COMPUTE, 31, 0, 0, 0, 0));
      pending_reqs.push_back(mk(OP_COMPUTE, 4, 0, 63, 63, 0));
      pending_reqs.push_back(mk(OP_COMPUTE, 8, 0, 2, 0, 0));
      pending_reqs.push_back(mk(OP_WEIGHT, 0, 0, 7, 7, 16'sh1234));
      pending_reqs.push_back(mk(OP_COMPUTE, 0, 0, 0, 0, 0));
      drain();
      // Random phases across several settings
      for (int s = 0; s < 6; s++) begin
         for (int i = 0; i < 6; i++) csr_put(3'(i), 7'(settings[s][i]));
         if (s != 4) load_all(0);
         for (int i = 0; i < 120; i++) begin
            if ($urandom_range(0, 3) == 0)
               pending_reqs.push_back(mk(OP_SAMPLE, $urandom, $urandom_range(0, 3),
                                         $urandom_range(0, 63), $urandom_range(0, 63),
                                         $urandom));
            else
               pending_reqs.push_back(rand_compute());
         end
         drain();
      end
      // Zero-size registers: kernel zero sums nothing, leaving only bias
      csr_put(REG_KERNEL_SIZE, 0);
      csr_put(REG_IN_CHANNELS, 0);
      for (int i = 0; i < 10; i++) pending_reqs.push_back(rand_compute());
      drain();
      if (mismatches == 0 && pixel_results.size() == 0)
         $display("conv2d_stride2_oc4_engine verification clean");
      else
         $display("conv2d_stride2_oc4_engine verification failed");
      $finish;
   end

   initial begin
      #60ms;
      $display("conv2d_stride2_oc4_engine verification failed");
      $finish;
   end
endmodule
